>>> src/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with a reset that disables it
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// a stalled signal keeps its value into the next cycle
`define CHK_ASSERT_STALL(label, clk, rst, vld, rdy, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
      else $error(msg);

`endif

>>> src/smeu_pkg.sv
// types and constants of the stack machine execute unit
package smeu_pkg;

   localparam int WORD_W   = 32;
   localparam int OPC_W    = 4;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 8;

   typedef enum logic [OPC_W-1:0] {
      OP_ICONST = 4'd0,
      OP_ADD    = 4'd1,
      OP_SUB    = 4'd2,
      OP_MUL    = 4'd3,
      OP_LT     = 4'd4,
      OP_GT     = 4'd5,
      OP_EQ     = 4'd6,
      OP_NEQ    = 4'd7,
      OP_BRT    = 4'd8,
      OP_BRF    = 4'd9,
      OP_CALL   = 4'd10,
      OP_RET    = 4'd11,
      OP_PRINT  = 4'd12,
      OP_HALT   = 4'd13
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_UNDER   = 3'd2,
      ST_OVER    = 3'd3,
      ST_HALTED  = 3'd4
   } status_type;

endpackage

>>> src/smeu_req_if.sv
// instruction channel: opcode and immediate
interface smeu_req_if;
   logic                            valid;
   logic                            ready;
   logic [smeu_pkg::OPC_W-1:0]      req_type;
   logic signed [smeu_pkg::WORD_W-1:0] immediate;

   modport source (output valid, output req_type, output immediate, input ready);
   modport sink   (input valid, input req_type, input immediate, output ready);
endinterface

>>> src/smeu_rsp_if.sv
// result channel: status, branch, print and stack state
interface smeu_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [smeu_pkg::STATUS_W-1:0]      status;
   logic                               branch_taken;
   logic signed [smeu_pkg::WORD_W-1:0] branch_target;
   logic                               print_valid;
   logic signed [smeu_pkg::WORD_W-1:0] print_value;
   logic                               halted_flag;
   logic [smeu_pkg::DEPTH_W-1:0]       depth_now;

   modport source (output valid, output status, output branch_taken, output branch_target,
                   output print_valid, output print_value, output halted_flag,
                   output depth_now, input ready);
   modport sink   (input valid, input status, input branch_taken, input branch_target,
                   input print_valid, input print_value, input halted_flag,
                   input depth_now, output ready);
endinterface

>>> src/smeu_ram.sv
// generic single write port ram with registered read
module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/smeu_alu.sv
// binary operations on the two top stack words
module smeu_alu (
   input  smeu_pkg::opcode_type        op,
   input  logic [smeu_pkg::WORD_W-1:0] lhs,
   input  logic [smeu_pkg::WORD_W-1:0] rhs,
   output logic [smeu_pkg::WORD_W-1:0] result
);

   always_comb begin
      unique case (op)
         smeu_pkg::OP_ADD: result = lhs + rhs;
         smeu_pkg::OP_SUB: result = lhs - rhs;
         smeu_pkg::OP_MUL: result = lhs * rhs;
         smeu_pkg::OP_LT:  result = smeu_pkg::WORD_W'($signed(lhs) < $signed(rhs));
         smeu_pkg::OP_GT:  result = smeu_pkg::WORD_W'($signed(lhs) > $signed(rhs));
         smeu_pkg::OP_EQ:  result = smeu_pkg::WORD_W'(lhs == rhs);
         smeu_pkg::OP_NEQ: result = smeu_pkg::WORD_W'(lhs != rhs);
         default:          result = '0;
      endcase
   end

endmodule

>>> src/stack_machine_execute_unit_core.sv
// stack machine execute unit: one instruction word in, one result word out
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   req_type, immediate
//   rsp_chan  out  valid/ready   status, branch_taken, branch_target, print_valid,
//                                print_value, halted_flag, depth_now
//
// an instruction executes in the cycle it is accepted; its result word is registered
// push, print, halt, call, ret and errors need no refill; add..neq, brt and brf refill
// when 3 or more entries were on the stack: the cached second entry is reloaded from
// the stack ram (one read port, registered read) before the next instruction is taken
// reset (synchronous) empties the stack and clears halt; the ram itself is not cleared
// a stalled result word holds, and a new word is still taken if rsp ready is high and no refill is pending
module stack_machine_execute_unit_core #(
   parameter int STACK_DEPTH = 128
) (
   input  logic          clock,
   input  logic          reset,
   smeu_req_if.sink      req_chan,
   smeu_rsp_if.source    rsp_chan
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int WW = smeu_pkg::WORD_W;

   // top two entries live in registers, the rest in the ram at their own index
   logic [CW-1:0] count_ff,   count_in;
   logic [WW-1:0] tos_ff,     tos_in;
   logic [WW-1:0] nos_ff,     nos_in;
   logic          stopped_ff, stopped_in;
   logic          refill_ff,  refill_in;
   logic          rsp_valid_ff;

   // registered result word
   logic [smeu_pkg::STATUS_W-1:0] status_ff,   status_in;
   logic                          taken_ff,    taken_in;
   logic [WW-1:0]                 target_ff,   target_in;
   logic                          pvalid_ff,   pvalid_in;
   logic [WW-1:0]                 pvalue_ff,   pvalue_in;
   logic                          halted_ff;
   logic [smeu_pkg::DEPTH_W-1:0]  depth_ff;

   logic                 accept;
   logic                 has_one, has_two, has_three, full;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [WW-1:0]        ram_rdata;
   logic [WW-1:0]        alu_result;
   smeu_pkg::opcode_type op;

   // a refill cycle blocks the next instruction, a full output register waits for rsp
   assign req_chan.ready = !refill_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign op        = smeu_pkg::opcode_type'(req_chan.req_type);
   assign has_one   = count_ff != '0;
   assign has_two   = count_ff >= CW'(2);
   assign has_three = count_ff >= CW'(3);
   assign full      = count_ff == CW'(STACK_DEPTH);

   // push spills the second entry to its slot, pops read the third entry back
   assign ram_waddr = AW'(count_ff - CW'(2));
   assign ram_raddr = AW'(count_ff - CW'(3));

   smeu_alu u_alu (
      .op     (op),
      .lhs    (nos_ff),
      .rhs    (tos_ff),
      .result (alu_result)
   );

   smeu_ram #(
      .WIDTH (WW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (nos_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // execute the accepted instruction against the cached top entries
   always_comb begin
      count_in   = count_ff;
      tos_in     = tos_ff;
      nos_in     = nos_ff;
      stopped_in = stopped_ff;
      refill_in  = 1'b0;
      ram_we     = 1'b0;
      status_in  = smeu_pkg::ST_OK;
      taken_in   = 1'b0;
      target_in  = '0;
      pvalid_in  = 1'b0;
      pvalue_in  = '0;

      if (stopped_ff) begin
         status_in = smeu_pkg::ST_HALTED;
      end else begin
         unique case (op)
            smeu_pkg::OP_ICONST: begin
               if (full) begin
                  status_in = smeu_pkg::ST_OVER;
               end else begin
                  ram_we   = accept && has_two;
                  tos_in   = req_chan.immediate;
                  nos_in   = tos_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_LT,
            smeu_pkg::OP_GT, smeu_pkg::OP_EQ, smeu_pkg::OP_NEQ: begin
               if (!has_two) begin
                  status_in = smeu_pkg::ST_UNDER;
               end else begin
                  tos_in    = alu_result;
                  count_in  = count_ff - CW'(1);
                  refill_in = has_three;
               end
            end
            smeu_pkg::OP_BRT, smeu_pkg::OP_BRF: begin
               if (!has_one) begin
                  status_in = smeu_pkg::ST_UNDER;
               end else begin
                  // flag is the top entry; brf takes the branch on zero
                  taken_in  = (op == smeu_pkg::OP_BRT) ? (tos_ff != '0) : (tos_ff == '0);
                  target_in = taken_in ? req_chan.immediate : '0;
                  tos_in    = nos_ff;
                  count_in  = count_ff - CW'(1);
                  refill_in = has_three;
               end
            end
            smeu_pkg::OP_CALL, smeu_pkg::OP_RET: begin
               // kept as no-ops
            end
            smeu_pkg::OP_PRINT: begin
               if (!has_one) begin
                  status_in = smeu_pkg::ST_UNDER;
               end else begin
                  pvalid_in = 1'b1;
                  pvalue_in = tos_ff;
               end
            end
            smeu_pkg::OP_HALT: begin
               stopped_in = 1'b1;
            end
            default: begin
               status_in = smeu_pkg::ST_UNKNOWN;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         refill_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         refill_ff <= accept && refill_in;
         if (accept) begin
            count_ff     <= count_in;
            stopped_ff   <= stopped_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // cached entries and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         tos_ff    <= tos_in;
         nos_ff    <= nos_in;
         status_ff <= status_in;
         taken_ff  <= taken_in;
         target_ff <= target_in;
         pvalid_ff <= pvalid_in;
         pvalue_ff <= pvalue_in;
         halted_ff <= stopped_in;
         depth_ff  <= smeu_pkg::DEPTH_W'(count_in);
      end else if (refill_ff) begin
         // third entry arrives from the ram in the cycle after the pop
         nos_ff <= ram_rdata;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.branch_taken  = taken_ff;
   assign rsp_chan.branch_target = target_ff;
   assign rsp_chan.print_valid   = pvalid_ff;
   assign rsp_chan.print_value   = pvalue_ff;
   assign rsp_chan.halted_flag   = halted_ff;
   assign rsp_chan.depth_now     = depth_ff;

endmodule

>>> src/smeu_checker.sv
// port checks of the stack machine execute unit, bound to the top level
`include "assert_macros.svh"

module smeu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [smeu_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_branch_taken,
   input logic [smeu_pkg::WORD_W-1:0]   rsp_branch_target,
   input logic                          rsp_print_valid,
   input logic [smeu_pkg::WORD_W-1:0]   rsp_print_value,
   input logic                          rsp_halted_flag
);

   logic halted_seen_ff, halted_seen_in;
   logic [smeu_pkg::STATUS_W+2*smeu_pkg::WORD_W+2:0] rsp_word;

   assign rsp_word = {rsp_status, rsp_branch_taken, rsp_branch_target, rsp_print_valid,
                      rsp_print_value, rsp_halted_flag};

   // a delivered word with the halt flag set stops the unit for good
   assign halted_seen_in = halted_seen_ff || (rsp_valid && rsp_ready && rsp_halted_flag);

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_seen_ff <= 1'b0;
      end else begin
         halted_seen_ff <= halted_seen_in;
      end
   end

   `CHK_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "rsp word dropped while stalled")
   `CHK_ASSERT_STALL(a_rsp_stable, clock, reset, rsp_valid, rsp_ready, rsp_word, "rsp word changed while stalled")
   `CHK_ASSERT(a_after_halt, clock, reset, (rsp_valid && halted_seen_ff) |-> (rsp_halted_flag && rsp_status == smeu_pkg::ST_HALTED), "instruction executed after halt")
   `CHK_ASSERT(a_error_quiet, clock, reset, (rsp_valid && rsp_status != smeu_pkg::ST_OK) |-> (!rsp_branch_taken && !rsp_print_valid && rsp_branch_target == '0 && rsp_print_value == '0), "failed instruction reports a branch or print")

endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_branch_taken  (rsp_chan.branch_taken),
   .rsp_branch_target (rsp_chan.branch_target),
   .rsp_print_valid   (rsp_chan.print_valid),
   .rsp_print_value   (rsp_chan.print_value),
   .rsp_halted_flag   (rsp_chan.halted_flag)
);

>>> tb/tb.sv
// self-checking testbench of the stack machine execute unit core
module tb;

   // stack size of the unit under test, kept equal to its parameter
   localparam int STACK_DEPTH   = 128;
   // random program length and the idle-free tail at its end
   localparam int RANDOM_WORDS  = 700;
   localparam int QUIET_WORDS   = 150;
   // long hold-off of the result side, asked for by the full-stack test
   localparam int STALL_CYCLES  = 150;
   // cycles let pass after the last result before the verdict
   localparam int DRAIN_CYCLES  = 8;
   // watchdog, far beyond the slowest correct run
   localparam int TIMEOUT_TICKS = 2000000;

   // the two opcodes that the unit does not decode
   localparam logic [smeu_pkg::OPC_W-1:0] OP_UNDEF_A = 4'd14;
   localparam logic [smeu_pkg::OPC_W-1:0] OP_UNDEF_B = 4'd15;

   // one result word as the predictor works it out
   typedef struct packed {
      logic [smeu_pkg::STATUS_W-1:0] status;
      logic                          taken;
      logic [smeu_pkg::WORD_W-1:0]   target;
      logic                          print_valid;
      logic [smeu_pkg::WORD_W-1:0]   print_value;
      logic                          halted;
      logic [smeu_pkg::DEPTH_W-1:0]  depth;
   } exec_result_type;

   logic clock = 1'b0;
   logic reset;

   smeu_req_if req_bus ();
   smeu_rsp_if rsp_bus ();

   stack_machine_execute_unit_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   // 10 time unit clock, first rising edge at 5
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: operand stack, entry count and halt
   logic [smeu_pkg::WORD_W-1:0] model_stack [STACK_DEPTH];
   int unsigned                 model_depth = 0;
   bit                          model_halted = 1'b0;

   // result words still owed by the unit, oldest first
   exec_result_type pending_results [$];
   int              error_count = 0;

   // random idling on both sides, and a request for the long hold-off
   bit idle_on       = 1'b1;
   bit stall_request = 1'b0;

   // executes one instruction on the predictor state and returns its result word
   function automatic exec_result_type execute_model(logic [smeu_pkg::OPC_W-1:0] op,
                                                     logic [smeu_pkg::WORD_W-1:0] imm);
      exec_result_type r;
      logic [smeu_pkg::WORD_W-1:0] a;
      logic [smeu_pkg::WORD_W-1:0] b;
      logic [smeu_pkg::WORD_W-1:0] flag;
      r = '0;
      r.status = smeu_pkg::ST_OK;
      if (model_halted) begin
         r.status = smeu_pkg::ST_HALTED;
      end else begin
         case (op)
            smeu_pkg::OP_ICONST: begin
               if (model_depth >= STACK_DEPTH) begin
                  r.status = smeu_pkg::ST_OVER;
               end else begin
                  model_stack[model_depth] = imm;
                  model_depth++;
               end
            end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_LT,
            smeu_pkg::OP_GT, smeu_pkg::OP_EQ, smeu_pkg::OP_NEQ: begin
               if (model_depth < 2) begin
                  r.status = smeu_pkg::ST_UNDER;
               end else begin
                  b = model_stack[model_depth-1];
                  a = model_stack[model_depth-2];
                  case (op)
                     smeu_pkg::OP_ADD: a = a + b;
                     smeu_pkg::OP_SUB: a = a - b;
                     smeu_pkg::OP_MUL: a = a * b;
                     smeu_pkg::OP_LT:  a = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                     smeu_pkg::OP_GT:  a = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
                     smeu_pkg::OP_EQ:  a = (a == b) ? 32'd1 : 32'd0;
                     default:          a = (a != b) ? 32'd1 : 32'd0;
                  endcase
                  model_stack[model_depth-2] = a;
                  model_depth--;
               end
            end
            smeu_pkg::OP_BRT, smeu_pkg::OP_BRF: begin
               if (model_depth < 1) begin
                  r.status = smeu_pkg::ST_UNDER;
               end else begin
                  flag = model_stack[model_depth-1];
                  model_depth--;
                  r.taken  = (op == smeu_pkg::OP_BRT) ? (flag != '0) : (flag == '0);
                  r.target = r.taken ? imm : '0;
               end
            end
            smeu_pkg::OP_CALL, smeu_pkg::OP_RET: begin
               // no effect on the stack
            end
            smeu_pkg::OP_PRINT: begin
               if (model_depth < 1) begin
                  r.status = smeu_pkg::ST_UNDER;
               end else begin
                  r.print_valid = 1'b1;
                  r.print_value = model_stack[model_depth-1];
               end
            end
            smeu_pkg::OP_HALT: begin
               model_halted = 1'b1;
            end
            default: begin
               r.status = smeu_pkg::ST_UNKNOWN;
            end
         endcase
      end
      r.halted = model_halted;
      r.depth  = model_depth[smeu_pkg::DEPTH_W-1:0];
      return r;
   endfunction

   // operand values weighted toward the extremes and small numbers
   function automatic logic [smeu_pkg::WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'h7fff_ffff;
         3:       return 32'h8000_0000;
         4:       return 32'hffff_ffff;
         5:       return 32'($urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   // random binary operation
   function automatic logic [smeu_pkg::OPC_W-1:0] rand_binary_op();
      return 4'($urandom_range(smeu_pkg::OP_ADD, smeu_pkg::OP_NEQ));
   endfunction

   // random opcode, never halt; push_pct sets how fast the stack grows
   function automatic logic [smeu_pkg::OPC_W-1:0] pick_opcode(int push_pct);
      int roll;
      if ($urandom_range(0, 99) < push_pct) return smeu_pkg::OP_ICONST;
      roll = $urandom_range(0, 99);
      if (roll < 55) return rand_binary_op();
      if (roll < 75) return $urandom_range(0, 1) ? smeu_pkg::OP_BRT : smeu_pkg::OP_BRF;
      if (roll < 85) return smeu_pkg::OP_PRINT;
      if (roll < 93) return $urandom_range(0, 1) ? smeu_pkg::OP_CALL : smeu_pkg::OP_RET;
      return $urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B;
   endfunction

   // offers one instruction word and books its result once it is taken
   // valid stays high after acceptance so back-to-back words need no second write
   task automatic send_instruction(logic [smeu_pkg::OPC_W-1:0] op,
                                   logic [smeu_pkg::WORD_W-1:0] imm);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= op;
      req_bus.immediate <= imm;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(execute_model(op, imm));
   endtask

   // underflow errors on an empty and on a one-entry stack
   task automatic test_empty_stack();
      send_instruction(smeu_pkg::OP_ADD, 32'h0);
      send_instruction(smeu_pkg::OP_BRF, 32'hffff_ffff);
      send_instruction(smeu_pkg::OP_PRINT, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'h7fff_ffff);
      send_instruction(smeu_pkg::OP_SUB, 32'h0);
   endtask

   // wrapping add, mul and sub at the signed extremes
   task automatic test_arithmetic();
      send_instruction(smeu_pkg::OP_ICONST, 32'h0000_0001);
      send_instruction(smeu_pkg::OP_ADD, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'hffff_ffff);
      send_instruction(smeu_pkg::OP_MUL, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'h8000_0000);
      send_instruction(smeu_pkg::OP_SUB, 32'h0);
      send_instruction(smeu_pkg::OP_PRINT, 32'h0);
   endtask

   // signed comparisons across the sign boundary, and equality
   task automatic test_compare();
      send_instruction(smeu_pkg::OP_ICONST, 32'h8000_0000);
      send_instruction(smeu_pkg::OP_GT, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'h7fff_ffff);
      send_instruction(smeu_pkg::OP_LT, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'h0000_0001);
      send_instruction(smeu_pkg::OP_EQ, 32'h0);
      send_instruction(smeu_pkg::OP_ICONST, 32'h0000_0000);
      send_instruction(smeu_pkg::OP_NEQ, 32'h0);
   endtask

   // both branches taken and not taken, targets at the extremes
   task automatic test_branch();
      send_instruction(smeu_pkg::OP_BRT, 32'h8000_0000);
      send_instruction(smeu_pkg::OP_ICONST, 32'h0);
      send_instruction(smeu_pkg::OP_BRF, 32'h7fff_ffff);
      send_instruction(smeu_pkg::OP_ICONST, 32'h0);
      send_instruction(smeu_pkg::OP_BRT, 32'hffff_ffff);
      send_instruction(smeu_pkg::OP_ICONST, 32'hffff_ffff);
      send_instruction(smeu_pkg::OP_BRF, 32'h1234_5678);
   endtask

   // call and ret do nothing, undecoded opcodes report and do not halt
   task automatic test_misc_opcodes();
      send_instruction(smeu_pkg::OP_CALL, 32'hffff_ffff);
      send_instruction(smeu_pkg::OP_RET, 32'h0);
      send_instruction(OP_UNDEF_A, 32'h0);
      send_instruction(OP_UNDEF_B, 32'hffff_ffff);
   endtask

   // fills the stack to overflow, beginning with a long result hold-off, then pops it down to one entry
   task automatic test_full_stack_backpressure();
      stall_request = 1'b1;
      while (model_depth < STACK_DEPTH) send_instruction(smeu_pkg::OP_ICONST, rand_word());
      send_instruction(smeu_pkg::OP_ICONST, rand_word());
      send_instruction(smeu_pkg::OP_ICONST, rand_word());
      send_instruction(smeu_pkg::OP_PRINT, 32'h0);
      while (model_depth > 1) send_instruction(rand_binary_op(), 32'h0);
      send_instruction(rand_binary_op(), 32'h0);
      send_instruction(rand_binary_op(), 32'h0);
   endtask

   // random program in chunks with different push rates; idle-free at the end
   task automatic test_random_program();
      int push_pct;
      push_pct = 50;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 50 == 0) begin
            case ($urandom_range(0, 3))
               0:       push_pct = 15;
               1:       push_pct = 40;
               2:       push_pct = 60;
               default: push_pct = 90;
            endcase
         end
         if (k == RANDOM_WORDS - QUIET_WORDS) idle_on = 1'b0;
         send_instruction(pick_opcode(push_pct), rand_word());
      end
   endtask

   // halt reports itself, then every opcode is ignored
   task automatic test_halt();
      send_instruction(smeu_pkg::OP_ICONST, 32'h5a5a_a5a5);
      send_instruction(smeu_pkg::OP_HALT, 32'hffff_ffff);
      for (int k = 0; k < 16; k++) send_instruction(4'(k), rand_word());
   endtask

   // one field of a result word against its expectation
   task automatic check_field(string field_name, logic [smeu_pkg::WORD_W-1:0] want,
                              logic [smeu_pkg::WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, field_name, want, got);
         error_count++;
      end
   endtask

   // result side: every accepted word is matched with the oldest expectation
   always @(posedge clock) begin : result_checker
      exec_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected, expected none actual status %0h",
                     $time, rsp_bus.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("branch_taken", 32'(want.taken), 32'(rsp_bus.branch_taken));
            check_field("branch_target", want.target, rsp_bus.branch_target);
            check_field("print_valid", 32'(want.print_valid), 32'(rsp_bus.print_valid));
            check_field("print_value", want.print_value, rsp_bus.print_value);
            check_field("halted_flag", 32'(want.halted), 32'(rsp_bus.halted_flag));
            check_field("depth_now", 32'(want.depth), 32'(rsp_bus.depth_now));
         end
      end
   end

   // result side ready: long hold-off on request, short random bursts otherwise
   initial begin : ready_driver
      int held;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (stall_request) begin
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < STALL_CYCLES) begin
               @(posedge clock);
               held++;
            end
            stall_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog for a hung handshake
   initial begin : watchdog
      #(TIMEOUT_TICKS);
      $display("FAILURE");
      $finish;
   end

   // test sequence
   initial begin : main_sequence
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= smeu_pkg::OP_ICONST;
      req_bus.immediate <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      test_arithmetic();
      test_compare();
      test_branch();
      test_misc_opcodes();
      test_full_stack_backpressure();
      test_random_program();
      test_halt();

      // all words taken; let the last results come out
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
